// ===== rtl/tlfr_pkg.sv =====
`default_nettype none

package tlfr_pkg;

  localparam int BYTE_W          = 8;
  localparam int IDX_W           = 10;
  localparam int LEN_W           = 16;
  localparam int KIND_W          = 2;
  localparam int OUT_TDATA_W     = 40;
  localparam int CFG_IDX_W       = 1;
  localparam int MAX_PAYLOAD_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAG_FIRST  = 1'b0,
    REG_TAG_SECOND = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER   = 2'd0,
    KIND_PAYLOAD  = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic [IDX_W-1:0]   byte_index;
    logic [LEN_W-1:0]   frame_length;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/tlfr_in_stage.sv =====
`default_nettype none

module tlfr_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [tlfr_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                        advance,
  output logic                             held_valid,
  output logic [tlfr_pkg::BYTE_W-1:0]      held_byte
);
  import tlfr_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  // The stage takes a new request whenever it is empty or is being drained.
  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

`default_nettype wire

// ===== rtl/tlfr_parser.sv =====
`default_nettype none

module tlfr_parser #(
  parameter int MAX_PAYLOAD = tlfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [tlfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic [tlfr_pkg::BYTE_W-1:0] tag_first,
  input  wire logic [tlfr_pkg::BYTE_W-1:0] tag_second,
  input  wire logic                        step,
  output logic                             has_result,
  output tlfr_pkg::result_t                res
);
  import tlfr_pkg::*;

  localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CMP_W = (POS_W > LEN_W) ? POS_W + 1 : LEN_W + 1;
  localparam int IXE_W = (POS_W > IDX_W) ? POS_W : IDX_W;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PAYLOAD);

  phase_t             phase_r, phase_nxt;
  logic               matched_r, matched_nxt;
  logic               low_seen_r, low_seen_nxt;
  logic [BYTE_W-1:0]  low_byte_r, low_byte_nxt;
  logic [LEN_W-1:0]   exp_len_r, exp_len_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  logic [LEN_W-1:0]   new_len;
  logic [CMP_W-1:0]   pos_inc_ext;
  logic [CMP_W-1:0]   len_ext;
  logic [IXE_W-1:0]   pos_idx_ext;
  logic               payload_done;

  assign new_len      = {rx_byte, low_byte_r};
  assign pos_inc_ext  = CMP_W'(pos_r) + CMP_W'(1);
  assign len_ext      = CMP_W'(exp_len_r);
  assign payload_done = (pos_inc_ext == len_ext);
  assign pos_idx_ext  = IXE_W'(pos_r);

  always_comb begin
    phase_nxt    = phase_r;
    matched_nxt  = matched_r;
    low_seen_nxt = low_seen_r;
    low_byte_nxt = low_byte_r;
    exp_len_nxt  = exp_len_r;
    pos_nxt      = pos_r;
    has_result   = 1'b0;
    res          = '{kind: KIND_HEADER, payload_byte: '0, byte_index: '0,
                     frame_length: exp_len_r, last: 1'b0};
    case (phase_r)
      PH_LEN: begin
        if (!low_seen_r) begin
          low_byte_nxt = rx_byte;
          low_seen_nxt = 1'b1;
        end else begin
          has_result       = 1'b1;
          exp_len_nxt      = new_len;
          low_seen_nxt     = 1'b0;
          pos_nxt          = '0;
          res.frame_length = new_len;
          if (new_len == '0) begin
            // An empty frame completes at its header.
            res.last    = 1'b1;
            phase_nxt   = PH_HUNT;
            matched_nxt = 1'b0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        has_result = 1'b1;
        if (pos_r >= MAX_POS) begin
          res.kind     = KIND_OVERFLOW;
          phase_nxt    = PH_HUNT;
          matched_nxt  = 1'b0;
          low_seen_nxt = 1'b0;
          pos_nxt      = '0;
        end else begin
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
          res.byte_index   = pos_idx_ext[IDX_W-1:0];
          res.last         = payload_done;
          pos_nxt          = pos_r + POS_W'(1);
          if (payload_done) begin
            phase_nxt    = PH_HUNT;
            matched_nxt  = 1'b0;
            low_seen_nxt = 1'b0;
            pos_nxt      = '0;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (!matched_r) begin
          matched_nxt = (rx_byte == tag_first);
        end else if (rx_byte == tag_second) begin
          matched_nxt  = 1'b0;
          low_seen_nxt = 1'b0;
          phase_nxt    = PH_LEN;
        end else begin
          // A wrong second byte may itself start a new tag.
          matched_nxt = (rx_byte == tag_first);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      matched_r  <= 1'b0;
      low_seen_r <= 1'b0;
      low_byte_r <= '0;
      exp_len_r  <= '0;
      pos_r      <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      matched_r  <= matched_nxt;
      low_seen_r <= low_seen_nxt;
      low_byte_r <= low_byte_nxt;
      exp_len_r  <= exp_len_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tlfr_out_stage.sv =====
`default_nettype none

module tlfr_out_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  input  wire tlfr_pkg::result_t                push_res,
  output logic                                  free,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [tlfr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [tlfr_pkg::KIND_W-1:0]           out_tuser,
  output logic                                  out_tlast
);
  import tlfr_pkg::*;

  localparam int PACK_W = BYTE_W + IDX_W + LEN_W;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = free ? push : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      res_r <= push_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - PACK_W){1'b0}}, res_r.frame_length,
                       res_r.byte_index, res_r.payload_byte};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

`default_nettype wire

// ===== rtl/tagged_length_frame_receiver_unit.sv =====
`default_nettype none

// Receives one byte per request and hunts for the two-byte tag set in the
// tag_first and tag_second registers, then reads a little-endian 16-bit
// length, reports a header result (kind 0) and one result per payload byte
// (kind 1) with its index; tlast marks the result that completes a frame,
// including the header of an empty frame. A payload byte arriving once the
// index has reached MAX_PAYLOAD gives an overflow result (kind 2) and the
// block returns to hunting. Bytes are taken at one per cycle unless a byte
// with a result waits for a full output register to drain; a result passes
// from the input register through the parser logic to the output register.
// Tag bytes and the low length byte are consumed without a result.
// Write the tag registers only while the block is idle.
module tagged_length_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = tlfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: rx_byte[7:0]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [tlfr_pkg::BYTE_W-1:0]      in_tdata,
  // out_tdata: payload_byte[7:0], byte_index[17:8], frame_length[33:18], zeros
  // out_tuser: kind[1:0]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [tlfr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [tlfr_pkg::KIND_W-1:0]           out_tuser,
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tlfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tlfr_pkg::BYTE_W-1:0]      cfg_data
);
  import tlfr_pkg::*;

  logic [BYTE_W-1:0] tag_first_r;
  logic [BYTE_W-1:0] tag_second_r;

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              advance;
  logic              has_result;
  logic              out_free;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_first_r  <= '0;
      tag_second_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TAG_FIRST:  tag_first_r  <= cfg_data;
        REG_TAG_SECOND: tag_second_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A byte without a result moves on even while the output register is full.
  assign advance = held_valid && (!has_result || out_free);

  tlfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  tlfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_byte    (held_byte),
    .tag_first  (tag_first_r),
    .tag_second (tag_second_r),
    .step       (advance),
    .has_result (has_result),
    .res        (res)
  );

  tlfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (advance && has_result),
    .push_res   (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
